// ===== rtl/core/telnet_rx_option_negotiator_unit_defines.svh =====
// Assertion macros shared by the telnet receive negotiator RTL.
`ifndef TELNET_RX_OPTION_NEGOTIATOR_UNIT_DEFINES_SVH
`define TELNET_RX_OPTION_NEGOTIATOR_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define TNRX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tnrx assertion failed");

// Check that a condition implies another in the next cycle.
`define TNRX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tnrx assertion failed");

`endif

// ===== rtl/core/tnrx_pkg.sv =====
// Types and constants of the telnet receive option negotiator.
`timescale 1ns / 1ps
`default_nettype none
package tnrx_pkg;

    localparam int OPTION_COUNT = 256;
    localparam logic [3:0] TERM_BYTES = 4'd8;

    // telnet commands
    localparam logic [7:0] C_SE   = 8'd240;
    localparam logic [7:0] C_GA   = 8'd249;
    localparam logic [7:0] C_SB   = 8'd250;
    localparam logic [7:0] C_WILL = 8'd251;
    localparam logic [7:0] C_WONT = 8'd252;
    localparam logic [7:0] C_DO   = 8'd253;
    localparam logic [7:0] C_DONT = 8'd254;
    localparam logic [7:0] C_IAC  = 8'd255;

    // options
    localparam logic [7:0] O_ECHO   = 8'd1;
    localparam logic [7:0] O_SGA    = 8'd3;
    localparam logic [7:0] O_STATUS = 8'd5;
    localparam logic [7:0] O_TM     = 8'd6;
    localparam logic [7:0] O_TTYPE  = 8'd24;
    localparam logic [7:0] O_NAWS   = 8'd31;
    localparam logic [7:0] O_MCCP1  = 8'd85;
    localparam logic [7:0] O_MCCP2  = 8'd86;

    localparam logic [7:0] SB_IS   = 8'd0;
    localparam logic [7:0] SB_SEND = 8'd1;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    // destinations
    localparam logic [1:0] D_DISPLAY = 2'd0;
    localparam logic [1:0] D_SERVER  = 2'd1;
    localparam logic [1:0] D_PROMPT  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_NL     = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_NAME   = 3'd3;
    localparam logic [2:0] REG_LEN    = 3'd4;

    typedef enum logic [2:0] {
        M_IDLE,
        M_IAC,
        M_VERB,
        M_SB,
        M_SB_IAC
    } t_mode;

    typedef enum logic [2:0] {
        K_DATA,
        K_PROMPT,
        K_CMD,
        K_CMD_NAWS,
        K_NAWS,
        K_TTYPE
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_job;

    typedef struct packed {
        logic        nl;
        logic [15:0] width;
        logic [15:0] height;
        logic [63:0] name;
        logic [3:0]  len;
    } t_cfg;

endpackage
`default_nettype wire

// ===== rtl/core/tnrx_front.sv =====
// Front part: parses received bytes, negotiates options, queues output jobs.
`timescale 1ns / 1ps
`default_nettype none
module tnrx_front import tnrx_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // rx_byte
    input  wire logic       i_full,
    output logic            o_push,
    output t_job            o_job
);

    // entry bits: 0 my_enabled, 1 his_enabled, 2 we_announced, 3 he_announced
    logic [3:0] r_mem [OPTION_COUNT];
    logic       r_vld [OPTION_COUNT];
    logic [3:0] r_rd;
    logic       r_rdv;

    logic       r_busy;
    logic [7:0] r_byte;
    t_mode      r_mode, n_mode;
    logic [7:0] r_verb, n_verb;
    logic [7:0] r_sub_opt, n_sub_opt;
    logic [7:0] r_sub_first, n_sub_first;
    logic [1:0] r_sub_cnt, n_sub_cnt;
    logic       r_his_mccp2;
    logic       r_my_ttype;

    logic       w_acc;
    logic       w_wr;
    logic [3:0] w_e, n_e;
    logic       w_cmd, w_naws;
    logic [7:0] w_cmd_verb;
    logic       w_sub_in;
    logic [7:0] w_sub_b;

    assign o_s_tready = !r_busy && !i_full;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_e        = r_rdv ? r_rd : 4'b0000;

    // read the option entry of the accepted byte and write back the updated entry
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd <= r_mem[i_s_tdata];
        end
        if (w_wr) begin
            r_mem[r_byte] <= n_e;
        end
    end

    // hold control state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rdv       <= 1'b0;
            r_mode      <= M_IDLE;
            r_verb      <= '0;
            r_sub_opt   <= '0;
            r_sub_first <= '0;
            r_sub_cnt   <= '0;
            r_his_mccp2 <= 1'b0;
            r_my_ttype  <= 1'b0;
            for (int i = 0; i < OPTION_COUNT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            if (w_acc) begin
                r_busy <= 1'b1;
                r_byte <= i_s_tdata;
                r_rdv  <= r_vld[i_s_tdata];
            end else if (r_busy) begin
                r_busy <= 1'b0;
            end
            if (r_busy) begin
                r_mode      <= n_mode;
                r_verb      <= n_verb;
                r_sub_opt   <= n_sub_opt;
                r_sub_first <= n_sub_first;
                r_sub_cnt   <= n_sub_cnt;
            end
            if (w_wr) begin
                r_vld[r_byte] <= 1'b1;
                if (r_byte == O_MCCP2) r_his_mccp2 <= n_e[1];
                if (r_byte == O_TTYPE) r_my_ttype  <= n_e[0];
            end
        end
    end

    // parse one byte and decide the reply
    always_comb begin
        n_mode      = r_mode;
        n_verb      = r_verb;
        n_sub_opt   = r_sub_opt;
        n_sub_first = r_sub_first;
        n_sub_cnt   = r_sub_cnt;
        n_e         = w_e;
        w_wr        = 1'b0;
        w_cmd       = 1'b0;
        w_naws      = 1'b0;
        w_cmd_verb  = C_DONT;
        w_sub_in    = 1'b0;
        w_sub_b     = r_byte;
        o_push      = 1'b0;
        o_job       = '{kind: K_DATA, b0: r_byte, b1: r_byte};
        if (r_busy) begin
            unique case (r_mode)
                M_IAC: begin
                    n_mode = M_IDLE;
                    if (r_byte == C_IAC) begin
                        o_push = 1'b1;
                    end else if (r_byte == C_WILL || r_byte == C_WONT ||
                                 r_byte == C_DO || r_byte == C_DONT) begin
                        n_verb = r_byte;
                        n_mode = M_VERB;
                    end else if (r_byte == C_SB) begin
                        n_sub_cnt   = '0;
                        n_sub_opt   = '0;
                        n_sub_first = '0;
                        n_mode      = M_SB;
                    end else if (r_byte == C_GA) begin
                        o_push     = 1'b1;
                        o_job.kind = K_PROMPT;
                    end
                end
                M_VERB: begin
                    n_mode = M_IDLE;
                    w_wr   = 1'b1;
                    priority if (r_verb == C_WILL) begin
                        n_e[3] = 1'b1;
                        if (!w_e[1]) begin
                            w_cmd = 1'b1;
                            if (r_byte == O_ECHO || r_byte == O_SGA || r_byte == O_STATUS ||
                                r_byte == O_TTYPE || r_byte == O_NAWS ||
                                r_byte == O_MCCP2 ||
                                (r_byte == O_MCCP1 && !r_his_mccp2)) begin
                                w_cmd_verb = C_DO;
                                n_e[1]     = 1'b1;
                            end else begin
                                w_cmd_verb = C_DONT;
                                n_e[1]     = 1'b0;
                            end
                        end
                    end else if (r_verb == C_WONT) begin
                        w_cmd      = w_e[1] || w_e[3];
                        w_cmd_verb = C_DONT;
                        n_e[1]     = 1'b0;
                        n_e[3]     = 1'b1;
                    end else if (r_verb == C_DO) begin
                        if (r_byte == O_TM) begin
                            w_cmd      = 1'b1;
                            w_cmd_verb = C_WILL;
                        end else if (!w_e[0]) begin
                            w_cmd = 1'b1;
                            if (r_byte == O_SGA || r_byte == O_STATUS ||
                                r_byte == O_NAWS || r_byte == O_TTYPE) begin
                                w_cmd_verb = C_WILL;
                                n_e[0]     = 1'b1;
                            end else begin
                                w_cmd_verb = C_WONT;
                                n_e[0]     = 1'b0;
                            end
                            n_e[2] = 1'b1;
                        end
                        w_naws = (r_byte == O_NAWS) && n_e[0];
                    end else begin
                        if (w_e[0] || !w_e[2]) begin
                            w_cmd      = 1'b1;
                            w_cmd_verb = C_WONT;
                            n_e[2]     = 1'b1;
                        end
                        n_e[0] = 1'b0;
                    end
                    o_push   = w_cmd || w_naws;
                    o_job.b0 = w_cmd_verb;
                    o_job.b1 = r_byte;
                    if (w_cmd && w_naws) o_job.kind = K_CMD_NAWS;
                    else if (w_naws)     o_job.kind = K_NAWS;
                    else                 o_job.kind = K_CMD;
                end
                M_SB: begin
                    if (r_byte == C_IAC) n_mode = M_SB_IAC;
                    else                 w_sub_in = 1'b1;
                end
                M_SB_IAC: begin
                    if (r_byte == C_SE) begin
                        n_mode     = M_IDLE;
                        o_push     = (r_sub_cnt == 2'd2) && (r_sub_opt == O_TTYPE) &&
                                     r_my_ttype && (r_sub_first == SB_SEND);
                        o_job.kind = K_TTYPE;
                    end else begin
                        n_mode   = M_SB;
                        w_sub_in = (r_byte == C_IAC);
                        w_sub_b  = C_IAC;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                    if (r_byte == C_IAC)     n_mode = M_IAC;
                    else if (r_byte != CH_CR) o_push = 1'b1;
                end
            endcase
            // keep the option byte and first data byte of a subnegotiation
            if (w_sub_in) begin
                if (r_sub_cnt == 2'd0)      n_sub_opt   = w_sub_b;
                else if (r_sub_cnt == 2'd1) n_sub_first = w_sub_b;
                if (r_sub_cnt != 2'd2)      n_sub_cnt   = r_sub_cnt + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tnrx_fifo.sv =====
// Job queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module tnrx_fifo import tnrx_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty,
    output logic      o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_buf [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_job   = r_buf[r_rp];

    // store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wp] <= i_job;
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tnrx_back.sv =====
// Back part: expands queued jobs into output words.
`timescale 1ns / 1ps
`default_nettype none
module tnrx_back import tnrx_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire t_job        i_job,
    input  wire logic        i_empty,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // dest[1:0], out_byte[9:2], zero fill
    output logic             o_m_tlast    // last
);

    typedef struct packed {
        logic [1:0] dest;
        logic [7:0] data;
        logic       skip;
    } t_slot;

    t_job       r_job;
    logic [3:0] r_step, n_step;
    logic       r_act;
    logic       r_m_valid;
    logic [9:0] r_m_data;
    logic       r_m_last;

    logic       w_gen, w_last;
    t_slot      w_cur, w_nxt;
    logic [3:0] w_n1;
    logic [3:0] w_len;

    // escape slot of a window size byte
    function automatic t_slot f_esc(input logic [7:0] b);
        f_esc = '{dest: D_SERVER, data: C_IAC, skip: (b != C_IAC)};
    endfunction

    // byte of one slot of a job
    function automatic t_slot f_slot(input t_job j, input logic [3:0] s, input t_cfg c);
        logic [2:0] idx;
        t_slot      r;
        idx = 3'(s - 4'd4);
        r   = '{dest: D_SERVER, data: C_IAC, skip: 1'b0};
        unique case (j.kind)
            K_DATA: begin
                r.dest = D_DISPLAY;
                r.data = j.b0;
            end
            K_PROMPT: begin
                if (s == 4'd0) r = '{dest: D_DISPLAY, data: CH_LF, skip: !c.nl};
                else           r = '{dest: D_PROMPT, data: 8'd0, skip: 1'b0};
            end
            K_TTYPE: begin
                unique case (s)
                    4'd0:    r.data = C_IAC;
                    4'd1:    r.data = C_SB;
                    4'd2:    r.data = O_TTYPE;
                    4'd3:    r.data = SB_IS;
                    4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11:
                             r.data = c.name[{idx, 3'b000} +: 8];
                    4'd13:   r.data = C_SE;
                    default: r.data = C_IAC;
                endcase
            end
            K_CMD, K_CMD_NAWS, K_NAWS: begin
                unique case (s)
                    4'd0:    r.data = C_IAC;
                    4'd1:    r.data = j.b0;
                    4'd2:    r.data = j.b1;
                    4'd3:    r.data = C_IAC;
                    4'd4:    r.data = C_SB;
                    4'd5:    r.data = O_NAWS;
                    4'd6:    r.data = c.width[15:8];
                    4'd7:    r      = f_esc(c.width[15:8]);
                    4'd8:    r.data = c.width[7:0];
                    4'd9:    r      = f_esc(c.width[7:0]);
                    4'd10:   r.data = c.height[15:8];
                    4'd11:   r      = f_esc(c.height[15:8]);
                    4'd12:   r.data = c.height[7:0];
                    4'd13:   r      = f_esc(c.height[7:0]);
                    4'd14:   r.data = C_IAC;
                    default: r.data = C_SE;
                endcase
            end
            default: r.data = C_IAC;
        endcase
        return r;
    endfunction

    // final slot of a job
    function automatic logic [3:0] f_end(input t_kind k);
        unique case (k)
            K_DATA:             f_end = 4'd0;
            K_PROMPT:           f_end = 4'd1;
            K_CMD:              f_end = 4'd2;
            K_TTYPE:            f_end = 4'd13;
            K_CMD_NAWS, K_NAWS: f_end = 4'd15;
            default:            f_end = 4'd0;
        endcase
    endfunction

    // first slot of a job
    function automatic logic [3:0] f_start(input t_kind k, input logic nl);
        priority if (k == K_NAWS)          f_start = 4'd3;
        else if (k == K_PROMPT && !nl)     f_start = 4'd1;
        else                               f_start = 4'd0;
    endfunction

    assign w_len  = (i_cfg.len > TERM_BYTES) ? TERM_BYTES : i_cfg.len;
    assign w_cur  = f_slot(r_job, r_step, i_cfg);
    assign w_n1   = r_step + 4'd1;
    assign w_nxt  = f_slot(r_job, w_n1, i_cfg);
    assign w_last = (r_step == f_end(r_job.kind));
    assign w_gen  = r_act && (!r_m_valid || i_m_tready);
    assign o_pop  = !i_empty && (!r_act || (w_gen && w_last));

    // step past name bytes beyond the length and unused escapes
    always_comb begin
        if (r_job.kind == K_TTYPE && w_n1 >= 4'd4 && w_n1 < 4'd12 &&
            w_n1 >= 4'd4 + w_len) begin
            n_step = 4'd12;
        end else if (w_nxt.skip) begin
            n_step = w_n1 + 4'd1;
        end else begin
            n_step = w_n1;
        end
    end

    // load the output register, the job and its step
    always_ff @(posedge i_clk) begin
        if (w_gen) begin
            r_m_data <= {w_cur.data, w_cur.dest};
            r_m_last <= w_last;
        end
        if (o_pop) begin
            r_job  <= i_job;
            r_step <= f_start(i_job.kind, i_cfg.nl);
        end else if (w_gen) begin
            r_step <= n_step;
        end
    end

    // track job and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (o_pop)                 r_act <= 1'b1;
            else if (w_gen && w_last)  r_act <= 1'b0;
            if (w_gen)            r_m_valid <= 1'b1;
            else if (i_m_tready)  r_m_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'b000000, r_m_data};
    assign o_m_tlast  = r_m_last;

endmodule
`default_nettype wire

// ===== rtl/core/telnet_rx_option_negotiator_unit.sv =====
// Top level of the telnet receive option negotiator.
`timescale 1ns / 1ps
`default_nettype none
`include "telnet_rx_option_negotiator_unit_defines.svh"
// Takes one received telnet byte per word and gives display bytes, prompt
// markers and reply bytes for the server. Bytes do not overlap: the option table
// is read in the cycle of acceptance and written back in the next. Results
// leave at one word per cycle while i_m_tready is high; a negotiation reply
// with a window size or terminal name yields up to sixteen words, absorbed by
// a job queue of QUEUE_DEPTH entries. The option table needs no clearing pass.
module telnet_rx_option_negotiator_unit import tnrx_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,    // rx_byte[7:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,    // dest[1:0], out_byte[9:2], zero fill
    output logic             o_m_tlast,    // last
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    t_cfg r_cfg;
    t_job w_push_job, w_pop_job;
    logic w_push, w_pop, w_empty, w_full;

    assign o_cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{nl: 1'b0, width: 16'd80, height: 16'd25, name: '0, len: '0};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NL:     r_cfg.nl     <= i_cfg_data[0];
                REG_WIDTH:  r_cfg.width  <= i_cfg_data[15:0];
                REG_HEIGHT: r_cfg.height <= i_cfg_data[15:0];
                REG_NAME:   r_cfg.name   <= i_cfg_data;
                REG_LEN:    r_cfg.len    <= i_cfg_data[3:0];
                default:    ;
            endcase
        end
    end

    tnrx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    tnrx_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    tnrx_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_job      (w_pop_job),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    `TNRX_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, w_push, !w_full || w_pop)
    `TNRX_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, w_pop, !w_empty)
    `TNRX_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    `TNRX_ASSERT_IMP(a_dest_legal, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[1:0] != 2'd3)

endmodule
`default_nettype wire

// ===== bench/tnrx_reply_checker.sv =====
// Checker that predicts and compares the words of the telnet receive negotiator.
`timescale 1ns / 1ps
module tnrx_reply_checker import tnrx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0] dest;
        logic [7:0] data;
        logic       last;
    } t_word;

    t_word reply_q[$];
    t_word burst[$];

    // shadow configuration
    logic        nl_on;
    logic [15:0] cols;
    logic [15:0] rows;
    logic [63:0] name;
    logic [3:0]  name_len;

    // shadow option tables and parser
    logic [255:0] us_on, him_on, us_told, him_told;
    t_mode        mode;
    logic [7:0]   verb;
    logic [7:0]   sub_opt;
    logic [7:0]   sub_first;
    logic [1:0]   sub_cnt;

    int errors = 0;
    int pend = 0;
    assign o_errors  = errors;
    assign o_pending = pend;

    task automatic report(input string msg);
        $display("tnrx check: %s at %0t", msg, $realtime);
        errors++;
    endtask

    task automatic put(input logic [1:0] d, input logic [7:0] b);
        t_word w;
        w = '{d, b, 1'b0};
        if (burst.size() < 16) burst = {burst, w};
    endtask

    task automatic put3(input logic [7:0] v, input logic [7:0] o);
        put(D_SERVER, C_IAC);
        put(D_SERVER, v);
        put(D_SERVER, o);
    endtask

    task automatic put_esc(input logic [7:0] b);
        put(D_SERVER, b);
        if (b == C_IAC) put(D_SERVER, C_IAC);
    endtask

    // apply one negotiation verb to the option tables
    task automatic negotiate(input logic [7:0] v, input logic [7:0] o);
        if (v == C_WILL) begin
            him_told[o] = 1'b1;
            if (!him_on[o]) begin
                if (o == O_ECHO || o == O_SGA || o == O_STATUS || o == O_TTYPE ||
                    o == O_NAWS) begin
                    put3(C_DO, o);
                    him_on[o] = 1'b1;
                end else if (o == O_MCCP1 && him_on[O_MCCP2]) begin
                    put3(C_DONT, o);
                end else if (o == O_MCCP1 || o == O_MCCP2) begin
                    put3(C_DO, o);
                    him_on[o] = 1'b1;
                end else begin
                    put3(C_DONT, o);
                end
            end
        end else if (v == C_WONT) begin
            if (him_on[o] || him_told[o]) put3(C_DONT, o);
            him_on[o]   = 1'b0;
            him_told[o] = 1'b1;
        end else if (v == C_DO) begin
            if (o == O_TM) begin
                put3(C_WILL, o);
            end else if (!us_on[o]) begin
                if (o == O_SGA || o == O_STATUS || o == O_NAWS || o == O_TTYPE) begin
                    put3(C_WILL, o);
                    us_on[o] = 1'b1;
                end else begin
                    put3(C_WONT, o);
                end
                us_told[o] = 1'b1;
            end
            if (o == O_NAWS && us_on[O_NAWS]) begin
                put(D_SERVER, C_IAC);
                put(D_SERVER, C_SB);
                put(D_SERVER, O_NAWS);
                put_esc(cols[15:8]);
                put_esc(cols[7:0]);
                put_esc(rows[15:8]);
                put_esc(rows[7:0]);
                put(D_SERVER, C_IAC);
                put(D_SERVER, C_SE);
            end
        end else begin
            if (us_on[o] || !us_told[o]) begin
                put3(C_WONT, o);
                us_told[o] = 1'b1;
            end
            us_on[o] = 1'b0;
        end
    endtask

    task automatic sub_take(input logic [7:0] b);
        if (sub_cnt == 2'd0) sub_opt = b;
        else if (sub_cnt == 2'd1) sub_first = b;
        if (sub_cnt < 2'd2) sub_cnt++;
    endtask

    // close a subnegotiation and answer a terminal type request
    task automatic sub_close();
        int n;
        if (sub_cnt >= 2'd2 && sub_opt == O_TTYPE && us_on[O_TTYPE] &&
            sub_first == SB_SEND) begin
            n = (name_len > TERM_BYTES) ? TERM_BYTES : name_len;
            put(D_SERVER, C_IAC);
            put(D_SERVER, C_SB);
            put(D_SERVER, O_TTYPE);
            put(D_SERVER, SB_IS);
            for (int i = 0; i < n; i++) put(D_SERVER, name[8*i +: 8]);
            put(D_SERVER, C_IAC);
            put(D_SERVER, C_SE);
        end
    endtask

    // work out the words caused by one received byte
    task automatic step_byte(input logic [7:0] ch);
        burst.delete();
        case (mode)
            M_IAC: begin
                mode = M_IDLE;
                if (ch == C_IAC) begin
                    put(D_DISPLAY, C_IAC);
                end else if (ch == C_WILL || ch == C_WONT || ch == C_DO ||
                             ch == C_DONT) begin
                    verb = ch;
                    mode = M_VERB;
                end else if (ch == C_SB) begin
                    sub_cnt   = 2'd0;
                    sub_opt   = 8'd0;
                    sub_first = 8'd0;
                    mode      = M_SB;
                end else if (ch == C_GA) begin
                    if (nl_on) put(D_DISPLAY, CH_LF);
                    put(D_PROMPT, 8'd0);
                end
            end
            M_VERB: begin
                mode = M_IDLE;
                negotiate(verb, ch);
            end
            M_SB: begin
                if (ch == C_IAC) mode = M_SB_IAC;
                else sub_take(ch);
            end
            M_SB_IAC: begin
                if (ch == C_SE) begin
                    mode = M_IDLE;
                    sub_close();
                end else begin
                    mode = M_SB;
                    if (ch == C_IAC) sub_take(C_IAC);
                end
            end
            default: begin
                mode = M_IDLE;
                if (ch == C_IAC) mode = M_IAC;
                else if (ch != CH_CR) put(D_DISPLAY, ch);
            end
        endcase
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        reply_q = {reply_q, burst};
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            nl_on    = 1'b0;
            cols     = 16'd80;
            rows     = 16'd25;
            name     = 64'd0;
            name_len = 4'd0;
            us_on    = '0;
            him_on   = '0;
            us_told  = '0;
            him_told = '0;
            mode     = M_IDLE;
            verb     = 8'd0;
            sub_opt  = 8'd0;
            sub_first = 8'd0;
            sub_cnt  = 2'd0;
            reply_q.delete();
        end else begin
            // compare the outgoing word before new predictions join the queue
            if (i_m_tvalid && i_m_tready) begin
                if (reply_q.size() == 0) begin
                    report($sformatf("unexpected word %h last %b", i_m_tdata, i_m_tlast));
                end else begin
                    if (i_m_tdata[1:0] != reply_q[0].dest)
                        report($sformatf("dest %0d want %0d", i_m_tdata[1:0],
                                         reply_q[0].dest));
                    if (i_m_tdata[9:2] != reply_q[0].data)
                        report($sformatf("byte %h want %h", i_m_tdata[9:2],
                                         reply_q[0].data));
                    if (i_m_tlast != reply_q[0].last)
                        report($sformatf("last %b want %b", i_m_tlast, reply_q[0].last));
                    void'(reply_q.pop_front());
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_NL:     nl_on    = i_cfg_data[0];
                    REG_WIDTH:  cols     = i_cfg_data[15:0];
                    REG_HEIGHT: rows     = i_cfg_data[15:0];
                    REG_NAME:   name     = i_cfg_data;
                    REG_LEN:    name_len = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) step_byte(i_s_tdata);
        end
        pend = reply_q.size();
    end

endmodule

// ===== bench/tb.sv =====
// Stimulus and verdict for the telnet receive negotiator.
`timescale 1ns / 1ps
module tb;
    import tnrx_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata = 8'd0;
    logic        i_m_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [63:0] i_cfg_data = 64'd0;
    logic        o_s_tready, o_m_tvalid, o_m_tlast, o_cfg_ready;
    logic [15:0] o_m_tdata;
    int          errors, pending;
    int          cycles = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    bit          held = 1'b0;
    bit          paused = 1'b0;
    int          next_cfg = 90;

    always #4 i_clk = ~i_clk;

    telnet_rx_option_negotiator_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tlast(o_m_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    tnrx_reply_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_m_tlast(o_m_tlast),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(99) >= 11);
        end
    end

    // offer one word and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        i_cfg_valid <= 1'b0;
        if (!calm && $urandom_range(99) < 11) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(negedge i_clk);
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // offer one register write; the next sender activity drops valid
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // pause the sender until every predicted word is out
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_all(input logic nl, input logic [15:0] w, input logic [15:0] h,
                           input logic [63:0] nm, input logic [3:0] len);
        drain();
        cfg_write(REG_NL, {63'd0, nl});
        cfg_write(REG_WIDTH, {48'd0, w});
        cfg_write(REG_HEIGHT, {48'd0, h});
        cfg_write(REG_NAME, nm);
        cfg_write(REG_LEN, {60'd0, len});
    endtask

    task automatic cmd3(input logic [7:0] v, input logic [7:0] o);
        send_byte(C_IAC);
        send_byte(v);
        send_byte(o);
    endtask

    task automatic sub_req(input logic [7:0] o, input logic [7:0] first);
        send_byte(C_IAC);
        send_byte(C_SB);
        send_byte(o);
        send_byte(first);
        send_byte(C_IAC);
        send_byte(C_SE);
    endtask

    function automatic logic [7:0] pick_opt();
        logic [7:0] opts [10] = '{O_ECHO, O_SGA, O_STATUS, O_TM, O_TTYPE, O_NAWS,
                                  O_MCCP1, O_MCCP2, 8'd255, 8'd0};
        if ($urandom_range(3) != 0) return opts[$urandom_range(9)];
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_verb();
        logic [7:0] verbs [4] = '{C_WILL, C_WONT, C_DO, C_DONT};
        return verbs[$urandom_range(3)];
    endfunction

    // one random sequence, mostly well formed
    task automatic rand_seq(output int n);
        int k;
        k = $urandom_range(0, 11);
        case (k)
            0, 1: begin
                send_byte(8'($urandom));
                n = 1;
            end
            2: begin
                send_byte(($urandom_range(1) != 0) ? CH_CR : CH_LF);
                n = 1;
            end
            3: begin
                send_byte(C_IAC);
                send_byte(($urandom_range(1) != 0) ? C_IAC : C_GA);
                n = 2;
            end
            4, 5, 6: begin
                cmd3(pick_verb(), pick_opt());
                n = 3;
            end
            7: begin
                cmd3(C_DO, ($urandom_range(1) != 0) ? O_NAWS : O_TTYPE);
                n = 3;
            end
            8: begin
                sub_req(($urandom_range(3) != 0) ? O_TTYPE : pick_opt(),
                        ($urandom_range(3) != 0) ? SB_SEND : 8'($urandom));
                n = 6;
            end
            9: begin
                // subnegotiation with escaped and broken IAC pairs inside
                send_byte(C_IAC);
                send_byte(C_SB);
                n = 2;
                repeat ($urandom_range(0, 4)) begin
                    if ($urandom_range(2) == 0) begin
                        send_byte(C_IAC);
                        send_byte(($urandom_range(1) != 0) ? C_IAC : 8'($urandom));
                        n += 2;
                    end else begin
                        send_byte(8'($urandom_range(0, 254)));
                        n++;
                    end
                end
                send_byte(C_IAC);
                send_byte(C_SE);
                n += 2;
            end
            default: begin
                // stray commands and noise
                send_byte(C_IAC);
                send_byte(($urandom_range(1) != 0) ? C_SE : 8'($urandom_range(240, 248)));
                n = 2;
            end
        endcase
    endtask

    initial begin
        int sent;
        int n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings first
        send_byte(8'h41);
        send_byte(CH_CR);
        send_byte(8'h00);
        send_byte(C_IAC); send_byte(C_IAC);
        send_byte(C_IAC); send_byte(C_GA);
        cmd3(C_WILL, O_ECHO);
        cmd3(C_WILL, O_MCCP2);
        cmd3(C_WILL, O_MCCP1);
        cmd3(C_WILL, 8'd255);
        cmd3(C_WONT, O_ECHO);
        cmd3(C_DO, O_TM);
        cmd3(C_DO, O_NAWS);
        cmd3(C_DO, 8'd255);
        cmd3(C_DONT, 8'd255);
        sub_req(O_TTYPE, SB_SEND);
        cmd3(C_DO, O_TTYPE);
        sub_req(O_TTYPE, SB_SEND);
        sub_req(O_STATUS, SB_SEND);
        send_byte(C_IAC); send_byte(C_SE);
        send_byte(C_IAC); send_byte(8'd241);
        send_byte(C_IAC); send_byte(C_SB); send_byte(C_IAC); send_byte(C_SE);

        // extremes: escaped window size, full and long names, ignored indexes
        set_all(1'b1, 16'hFFFF, 16'h00FF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        cfg_write(3'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(3'd7, 64'd0);
        send_byte(C_IAC); send_byte(C_GA);
        cmd3(C_DO, O_NAWS);
        sub_req(O_TTYPE, SB_SEND);
        set_all(1'b0, 16'd0, 16'd0, {$urandom, $urandom}, 4'd15);
        cmd3(C_DO, O_NAWS);
        sub_req(O_TTYPE, SB_SEND);

        // random part in several settings
        sent = 0;
        while (sent < 368) begin
            if (sent >= next_cfg) begin
                set_all($urandom_range(1), 16'($urandom), 16'($urandom),
                        {$urandom, $urandom}, 4'($urandom_range(0, 15)));
                next_cfg += 90;
            end
            calm = (sent >= 120 && sent < 200);
            if (sent >= 240 && !held) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            if (sent >= 300 && !paused) begin
                drain();
                paused = 1'b1;
            end
            rand_seq(n);
            sent += n;
        end
        calm = 1'b0;
        set_all(1'b1, 16'd80, 16'd25, 64'h0000_0074_7278_6576, 4'd0);
        sub_req(O_TTYPE, SB_SEND);
        cmd3(C_DO, O_NAWS);

        drain();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
